// ----- rtl/jcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// jcsg_pkg
// Shared types and constants for the joint command safety gate.
// ----------------------------------------------------------------------------
package jcsg_pkg;

	localparam int MAX_JOINTS = 8;
	localparam int VALUE_BITS = 32;
	localparam int JOINT_W    = 3;
	localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
	localparam int TICK_W     = 16;
	localparam int MODE_W     = 2;
	localparam int SRC_W      = 2;
	localparam int CMD_W      = 3;

	localparam int IN_TDATA_W  = ((JOINT_W + 2 * VALUE_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((JOINT_W + VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 1 + SRC_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_REF    = 3'd0,
		CMD_POS    = 3'd1,
		CMD_LIMIT  = 3'd2,
		CMD_ESTOP  = 3'd3,
		CMD_TICK   = 3'd4,
		CMD_UPDATE = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 2'd0,
		REG_TIMEOUT = 2'd1,
		REG_JCOUNT  = 2'd2
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;

	localparam logic [SRC_W-1:0] SRC_NORMAL   = 2'd0;
	localparam logic [SRC_W-1:0] SRC_ESTOP    = 2'd1;
	localparam logic [SRC_W-1:0] SRC_WATCHDOG = 2'd2;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// Per-step control from the sequencer to the datapath.
	typedef struct packed {
		logic               active;
		logic               advance;
		logic [JOINT_W-1:0] idx;
		logic               emit;
		logic               last;
		logic               copy;
	} walk_t;

endpackage

// ----- rtl/jcsg_unit.sv -----
// ----------------------------------------------------------------------------
// jcsg_unit
// Shared command unit: picks the command source for one joint and clamps
// the reference to the joint limits.
// ----------------------------------------------------------------------------
module jcsg_unit (
	input  logic [jcsg_pkg::VALUE_BITS-1:0] ref_val,
	input  logic [jcsg_pkg::VALUE_BITS-1:0] lo,
	input  logic [jcsg_pkg::VALUE_BITS-1:0] hi,
	input  logic [jcsg_pkg::VALUE_BITS-1:0] hold_val,
	input  logic                            ref_ok,
	input  logic                            stop_engaged,
	input  logic                            timed_out,
	input  logic                            posmode,
	output logic [jcsg_pkg::VALUE_BITS-1:0] cv,
	output logic                            valid,
	output logic [jcsg_pkg::SRC_W-1:0]      src
);

	logic [jcsg_pkg::VALUE_BITS-1:0] upper_lim;
	logic [jcsg_pkg::VALUE_BITS-1:0] clamped;

	always_comb begin
		// upper first, then lower: crossed limits resolve to lower
		upper_lim = ($signed(ref_val) > $signed(hi)) ? hi : ref_val;
		clamped   = ($signed(upper_lim) < $signed(lo)) ? lo : upper_lim;
		if ((lo == '0) && (hi == '0)) begin
			clamped = ref_val;
		end
	end

	always_comb begin
		cv    = '0;
		valid = 1'b1;
		src   = jcsg_pkg::SRC_NORMAL;
		if (stop_engaged) begin
			cv  = posmode ? hold_val : '0;
			src = jcsg_pkg::SRC_ESTOP;
		end else if (timed_out && !posmode) begin
			src = jcsg_pkg::SRC_WATCHDOG;
		end else if (!ref_ok) begin
			valid = 1'b0;
		end else begin
			cv = clamped;
		end
	end

endmodule

// ----- rtl/jcsg_seq.sv -----
// ----------------------------------------------------------------------------
// jcsg_seq
// Update sequencer: walks the joint index one step per free output slot.
// ----------------------------------------------------------------------------
module jcsg_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [jcsg_pkg::CNT_W-1:0] start_limit,
	input  logic [jcsg_pkg::CNT_W-1:0] start_n,
	input  logic                       start_copy,
	input  logic                       out_free,
	output logic                       busy,
	output jcsg_pkg::walk_t            walk
);

	jcsg_pkg::state_t                state_q, state_d;
	logic [jcsg_pkg::JOINT_W-1:0]    idx_q, idx_d;
	logic [jcsg_pkg::CNT_W-1:0]      limit_q, n_q;
	logic                            copy_q;
	logic [jcsg_pkg::CNT_W-1:0]      idx_ext;

	assign idx_ext = jcsg_pkg::CNT_W'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jcsg_pkg::ST_IDLE;
			idx_q   <= '0;
			limit_q <= '0;
			n_q     <= '0;
			copy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (start) begin
				limit_q <= start_limit;
				n_q     <= start_n;
				copy_q  <= start_copy;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		busy         = 1'b0;
		walk.active  = 1'b0;
		walk.advance = 1'b0;
		walk.idx     = idx_q;
		walk.emit    = idx_ext < n_q;
		walk.last    = (idx_ext + 1'b1) == n_q;
		walk.copy    = copy_q;
		unique case (state_q)
			jcsg_pkg::ST_IDLE: begin
				idx_d = '0;
				if (start) begin
					state_d = jcsg_pkg::ST_WALK;
				end
			end
			jcsg_pkg::ST_WALK: begin
				busy         = 1'b1;
				walk.active  = 1'b1;
				walk.advance = out_free;
				if (out_free) begin
					idx_d = idx_q + 1'b1;
					if ((idx_ext + 1'b1) == limit_q) begin
						state_d = jcsg_pkg::ST_IDLE;
						idx_d   = '0;
					end
				end
			end
			default: begin
				state_d = jcsg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/joint_command_safety_gate_unit.sv -----
// ----------------------------------------------------------------------------
// joint_command_safety_gate_unit
// Per-joint actuator command gate with e-stop hold, watchdog and limits.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+--------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser         | in, items
//  m_*     | m_tvalid m_tready m_tdata m_tuser m_tlast | out, commands
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data    | in, registers
//
//  Store, limit, e-stop and tick items are taken without a walk; so is a release.
//  An update walks one sequencer step per joint in use, or a step for every
//  joint when an engage edge in position mode copies measured positions into
//  the hold store.
//  A stalled m_tready freezes the walk; s_tready stays low until it ends.
//  Reset is asynchronous and takes effect at once; no clearing pass.
// ----------------------------------------------------------------------------
module joint_command_safety_gate_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// joint[2:0], value[34:3], value_high[66:35], estop_request[67], zero pad
	input  logic [jcsg_pkg::IN_TDATA_W-1:0]     s_tdata,
	// cmd[2:0]
	input  logic [jcsg_pkg::CMD_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_joint[2:0], actuator_cmd[34:3], zero pad
	output logic [jcsg_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// command_valid[0], source[2:1]
	output logic [jcsg_pkg::OUT_TUSER_W-1:0]    m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jcsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int VB = jcsg_pkg::VALUE_BITS;
	localparam int JW = jcsg_pkg::JOINT_W;
	localparam int NJ = jcsg_pkg::MAX_JOINTS;

	// input fields
	logic [JW-1:0] in_joint;
	logic [VB-1:0] in_value;
	logic [VB-1:0] in_value_high;
	logic          in_req;

	assign in_joint      = s_tdata[JW-1:0];
	assign in_value      = s_tdata[JW +: VB];
	assign in_value_high = s_tdata[JW + VB +: VB];
	assign in_req        = s_tdata[JW + 2 * VB];

	// configuration
	logic [jcsg_pkg::MODE_W-1:0] mode_q;
	logic [jcsg_pkg::TICK_W-1:0] timeout_q;
	logic [3:0]                  jcount_q;

	// state
	logic [VB-1:0] ref_q   [NJ];
	logic [VB-1:0] meas_q  [NJ];
	logic [VB-1:0] hold_q  [NJ];
	logic [VB-1:0] lo_q    [NJ];
	logic [VB-1:0] hi_q    [NJ];
	logic [NJ-1:0] ref_ok_q;
	logic          stop_req_q;
	logic          stop_eng_q;
	logic          timed_out_q;
	logic [jcsg_pkg::TICK_W-1:0] idle_q;

	logic                          posmode;
	logic                          in_acc;
	logic                          busy;
	logic                          out_free;
	logic                          is_update;
	logic                          engage;
	logic                          release_edge;
	logic [jcsg_pkg::CNT_W-1:0]    n_sat;
	logic [jcsg_pkg::CNT_W-1:0]    limit;
	logic                          start;
	logic                          joint_ok;
	logic [jcsg_pkg::TICK_W-1:0]   idle_next;
	jcsg_pkg::walk_t               walk;

	logic [VB-1:0]                 hold_sel;
	logic [VB-1:0]                 cv;
	logic                          cvalid;
	logic [jcsg_pkg::SRC_W-1:0]    csrc;

	// output register
	logic                          m_valid_q;
	logic [JW-1:0]                 o_joint_q;
	logic [VB-1:0]                 o_value_q;
	logic                          o_valid_q;
	logic [jcsg_pkg::SRC_W-1:0]    o_src_q;
	logic                          o_last_q;

	assign posmode   = (mode_q == jcsg_pkg::MODE_POSITION);
	assign s_tready  = !busy;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign joint_ok  = 32'(in_joint) < NJ;

	assign is_update    = in_acc && (s_tuser == jcsg_pkg::CMD_UPDATE);
	assign engage       = stop_req_q && !stop_eng_q;
	assign release_edge = !stop_req_q && stop_eng_q;

	always_comb begin
		n_sat = (32'(jcount_q) > NJ) ? jcsg_pkg::CNT_W'(NJ) : jcsg_pkg::CNT_W'(jcount_q);
		// a latch of hold values has to visit every joint
		limit = (engage && posmode) ? jcsg_pkg::CNT_W'(NJ) : n_sat;
		start = is_update && !release_edge && (limit != '0);
	end

	always_comb begin
		idle_next = (idle_q < timeout_q) ? idle_q + 1'b1 : idle_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jcsg_pkg::MODE_VELOCITY;
			timeout_q <= jcsg_pkg::TICK_W'(100);
			jcount_q  <= 4'(NJ);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jcsg_pkg::REG_MODE:    mode_q    <= cfg_data[jcsg_pkg::MODE_W-1:0];
				jcsg_pkg::REG_TIMEOUT: timeout_q <= cfg_data[jcsg_pkg::TICK_W-1:0];
				jcsg_pkg::REG_JCOUNT:  jcount_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// item handling and per-joint stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NJ; i++) begin
				ref_q[i]  <= '0;
				meas_q[i] <= '0;
				hold_q[i] <= '0;
				lo_q[i]   <= '0;
				hi_q[i]   <= '0;
			end
			ref_ok_q    <= '1;
			stop_req_q  <= 1'b0;
			stop_eng_q  <= 1'b0;
			timed_out_q <= 1'b0;
			idle_q      <= '0;
		end else begin
			if (in_acc) begin
				unique case (s_tuser)
					jcsg_pkg::CMD_REF: begin
						if (joint_ok) begin
							ref_q[in_joint]    <= in_value;
							ref_ok_q[in_joint] <= 1'b1;
							idle_q             <= '0;
							timed_out_q        <= 1'b0;
						end
					end
					jcsg_pkg::CMD_POS: begin
						if (joint_ok) begin
							meas_q[in_joint] <= in_value;
						end
					end
					jcsg_pkg::CMD_LIMIT: begin
						if (joint_ok) begin
							lo_q[in_joint] <= in_value;
							hi_q[in_joint] <= in_value_high;
						end
					end
					jcsg_pkg::CMD_ESTOP: begin
						stop_req_q <= in_req;
					end
					jcsg_pkg::CMD_TICK: begin
						if (!posmode) begin
							idle_q <= idle_next;
							if (idle_next >= timeout_q) begin
								timed_out_q <= 1'b1;
							end
						end
					end
					jcsg_pkg::CMD_UPDATE: begin
						if (engage) begin
							stop_eng_q <= 1'b1;
						end else if (release_edge) begin
							stop_eng_q <= 1'b0;
							ref_ok_q   <= '0;
						end
					end
					default: ;
				endcase
			end
			// hold latch runs along with the walk, one joint a step
			if (walk.active && walk.advance && walk.copy) begin
				hold_q[walk.idx] <= meas_q[walk.idx];
			end
		end
	end

	jcsg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_limit (limit),
		.start_n     (n_sat),
		.start_copy  (engage && posmode),
		.out_free    (out_free),
		.busy        (busy),
		.walk        (walk)
	);

	assign hold_sel = walk.copy ? meas_q[walk.idx] : hold_q[walk.idx];

	jcsg_unit u_unit (
		.ref_val      (ref_q[walk.idx]),
		.lo           (lo_q[walk.idx]),
		.hi           (hi_q[walk.idx]),
		.hold_val     (hold_sel),
		.ref_ok       (ref_ok_q[walk.idx]),
		.stop_engaged (stop_eng_q),
		.timed_out    (timed_out_q),
		.posmode      (posmode),
		.cv           (cv),
		.valid        (cvalid),
		.src          (csrc)
	);

	// output register: loads on an emitting step, drains on m_tready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (walk.active && walk.advance && walk.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk.active && walk.advance && walk.emit) begin
			o_joint_q <= walk.idx;
			o_value_q <= cv;
			o_valid_q <= cvalid;
			o_src_q   <= csrc;
			o_last_q  <= walk.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(jcsg_pkg::OUT_TDATA_W - JW - VB){1'b0}}, o_value_q, o_joint_q};
	assign m_tuser  = {o_src_q, o_valid_q};
	assign m_tlast  = o_last_q;

endmodule
